FILE: rtl/text_console_writer_macros.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shorthand for the clocked, reset-qualified checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Item types, field widths, op codes and register indexes.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int TROW_W = 6;
    localparam int POS_W  = 11;
    localparam int IDX_W  = 12;
    localparam int CHAR_W = 8;
    localparam int CLR_W  = 4;
    localparam int CELL_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Largest geometry the register widths can express
    localparam int COL_CFG_LIMIT = 127;
    localparam int ROW_CFG_LIMIT = 31;

    localparam logic [1:0] OP_PUT_CHAR     = 2'd0;
    localparam logic [1:0] OP_SET_POSITION = 2'd1;
    localparam logic [1:0] OP_READ_CELL    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_FG     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BG     = 2'd3;

    localparam logic [COL_W-1:0] RST_COLUMNS = 7'd80;
    localparam logic [ROW_W-1:0] RST_ROWS    = 5'd25;
    localparam logic [CLR_W-1:0] RST_FG      = 4'd7;
    localparam logic [CLR_W-1:0] RST_BG      = 4'd0;

    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [CELL_W-1:0] RESET_CELL   = 16'h0020;

    typedef struct packed {
        logic [1:0]        op;
        logic [CHAR_W-1:0] char_code;
        logic [CLR_W-1:0]  fg_color;
        logic [CLR_W-1:0]  bg_color;
        logic [COL_W-1:0]  column;
        logic [TROW_W-1:0] row;
    } cmd_t;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [CHAR_W-1:0] cell_char;
        logic [CHAR_W-1:0] cell_attr;
        logic              scrolled;
    } rsp_t;

endpackage

FILE: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode screen engine: cell store, cursor, wrap and upward scroll.
// ----------------------------------------------------------------------------
// The screen lives in one single-port-write, registered-read memory of
// MAX_COLUMNS*MAX_ROWS cells (character in the low byte, attribute in the
// high byte). After reset the block runs a clearing pass over all
// MAX_COLUMNS*MAX_ROWS cells (2000 at the defaults) and takes no item until
// it ends; configuration writes are taken throughout. A put_char or
// set_position item without scroll goes from the idle state straight to the
// hand-off state; a read_cell item first passes a read-wait state for the
// registered memory read. Each scroll walks the store through the memory
// port: it moves every cell below the top row up by one row, drains the last
// move, then refills the bottom row (a one-row screen has nothing to move);
// set_position can scroll up to 63 rows in one item. A finished result waits
// in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
`include "text_console_writer_macros.svh"

module text_console_writer #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 25
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_ready,
    input  tcw_pkg::cmd_t                      cmd,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output tcw_pkg::rsp_t                      rsp,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    // Geometry caps: the smaller of the store size and what the registers hold
    localparam int COLS_CAP = (MAX_COLUMNS < tcw_pkg::COL_CFG_LIMIT) ?
                              MAX_COLUMNS : tcw_pkg::COL_CFG_LIMIT;
    localparam int ROWS_CAP = (MAX_ROWS < tcw_pkg::ROW_CFG_LIMIT) ?
                              MAX_ROWS : tcw_pkg::ROW_CFG_LIMIT;

    localparam int COL_W  = tcw_pkg::COL_W;
    localparam int ROW_W  = tcw_pkg::ROW_W;
    localparam int TROW_W = tcw_pkg::TROW_W;
    localparam int IDX_W  = tcw_pkg::IDX_W;
    localparam int CELL_W = tcw_pkg::CELL_W;
    localparam int CLR_W  = tcw_pkg::CLR_W;
    localparam int CHAR_W = tcw_pkg::CHAR_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_MOVE,
        S_FILL,
        S_DONE
    } state_t;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t               state_reg;
    logic [ADDR_W-1:0]    clr_reg;
    logic [IDX_W-1:0]     src_reg;
    logic [IDX_W-1:0]     fill_reg;
    logic [IDX_W-1:0]     mv_dst_reg;
    logic                 mv_pend_reg;
    logic [TROW_W-1:0]    scroll_left_reg;
    logic [COL_W-1:0]     cur_col_reg;
    logic [ROW_W-1:0]     cur_row_reg;
    logic [CHAR_W-1:0]    res_char_reg;
    logic [CHAR_W-1:0]    res_attr_reg;
    logic                 res_scroll_reg;
    logic                 rsp_valid_reg;
    tcw_pkg::rsp_t        rsp_reg;

    logic [COL_W-1:0]     cfg_cols_reg;
    logic [ROW_W-1:0]     cfg_rows_reg;
    logic [CLR_W-1:0]     cfg_fg_reg;
    logic [CLR_W-1:0]     cfg_bg_reg;

    logic [CELL_W-1:0]    mem [CELL_COUNT];
    logic [CELL_W-1:0]    rd_data_reg;

    // ------------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------------
    logic [COL_W-1:0]     cols;
    logic [ROW_W-1:0]     rows;
    logic [IDX_W-1:0]     area;
    logic [IDX_W-1:0]     last_base;
    logic [COL_W-1:0]     cur_col_sat;
    logic [ROW_W-1:0]     cur_row_sat;
    logic [COL_W-1:0]     tcol_sat;
    logic [ROW_W-1:0]     trow_sat;
    logic [COL_W-1:0]     mul_col;
    logic [ROW_W-1:0]     mul_row;
    logic [IDX_W-1:0]     acc_idx;
    logic [COL_W:0]       put_col1;
    logic                 put_wrap;
    logic [ROW_W:0]       put_row1;
    logic                 put_scroll;
    logic [COL_W-1:0]     nxt_col;
    logic [ROW_W-1:0]     nxt_row;
    logic [TROW_W-1:0]    nxt_scroll_cnt;
    logic                 accept;
    logic                 load_ok;
    logic [IDX_W-1:0]     pos_full;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [CELL_W-1:0]    wr_data;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 in_walk;
    logic                 hold_phase;

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign load_ok   = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // Effective geometry: zero reads as one, oversize saturates at the cap
    always_comb
    begin
        if (cfg_cols_reg == '0)
            cols = COL_W'(1);
        else if (int'(cfg_cols_reg) > COLS_CAP)
            cols = COL_W'(COLS_CAP);
        else
            cols = cfg_cols_reg;

        if (cfg_rows_reg == '0)
            rows = ROW_W'(1);
        else if (int'(cfg_rows_reg) > ROWS_CAP)
            rows = ROW_W'(ROWS_CAP);
        else
            rows = cfg_rows_reg;
    end

    assign area      = IDX_W'(rows) * IDX_W'(cols);
    assign last_base = area - IDX_W'(cols);

    // Saturate a stale cursor and the target coordinates to the screen
    assign cur_col_sat = (cur_col_reg >= cols) ? COL_W'(cols - COL_W'(1)) : cur_col_reg;
    assign cur_row_sat = (cur_row_reg >= rows) ? ROW_W'(rows - ROW_W'(1)) : cur_row_reg;
    assign tcol_sat    = (cmd.column >= cols) ? COL_W'(cols - COL_W'(1)) : cmd.column;
    assign trow_sat    = (cmd.row >= {1'b0, rows}) ? ROW_W'(rows - ROW_W'(1))
                                                   : cmd.row[ROW_W-1:0];

    // Cell address of the access made at accept time
    assign mul_col = (cmd.op == tcw_pkg::OP_READ_CELL) ? tcol_sat : cur_col_sat;
    assign mul_row = (cmd.op == tcw_pkg::OP_READ_CELL) ? trow_sat : cur_row_sat;
    assign acc_idx = IDX_W'(mul_row) * IDX_W'(cols) + IDX_W'(mul_col);

    // Cursor advance for put_char
    assign put_col1   = {1'b0, cur_col_sat} + (COL_W+1)'(1);
    assign put_wrap   = (put_col1 >= {1'b0, cols});
    assign put_row1   = {1'b0, cur_row_sat} + {{ROW_W{1'b0}}, put_wrap};
    assign put_scroll = (put_row1 >= {1'b0, rows});

    always_comb
    begin
        nxt_col        = cur_col_sat;
        nxt_row        = cur_row_sat;
        nxt_scroll_cnt = '0;
        case (cmd.op)
            tcw_pkg::OP_PUT_CHAR:
            begin
                nxt_col = (put_wrap || put_scroll) ? '0 : put_col1[COL_W-1:0];
                nxt_row = put_scroll ? ROW_W'(rows - ROW_W'(1)) : put_row1[ROW_W-1:0];
                nxt_scroll_cnt = put_scroll ? TROW_W'(1) : '0;
            end
            tcw_pkg::OP_SET_POSITION:
            begin
                nxt_col = tcol_sat;
                nxt_row = trow_sat;
                // One scroll for each row beyond the last
                if (cmd.row >= {1'b0, rows})
                    nxt_scroll_cnt = cmd.row - TROW_W'(rows - ROW_W'(1));
            end
            default:
            begin
                nxt_col = cur_col_sat;
                nxt_row = cur_row_sat;
            end
        endcase
    end

    // Memory port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(acc_idx);
        wr_data = {cmd.bg_color, cmd.fg_color, cmd.char_code};
        rd_addr = ADDR_W'(acc_idx);
        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = tcw_pkg::RESET_CELL;
            end
            S_IDLE:
            begin
                wr_en = accept && (cmd.op == tcw_pkg::OP_PUT_CHAR);
            end
            S_MOVE, S_FILL:
            begin
                rd_addr = ADDR_W'(src_reg);
                if (mv_pend_reg)
                begin
                    // Drain the moved cell read in the previous cycle
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(mv_dst_reg);
                    wr_data = rd_data_reg;
                end
                else if (state_reg == S_FILL)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(fill_reg);
                    wr_data = {cfg_bg_reg, cfg_fg_reg, tcw_pkg::BLANK_CHAR};
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Screen store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_cols_reg <= tcw_pkg::RST_COLUMNS;
            cfg_rows_reg <= tcw_pkg::RST_ROWS;
            cfg_fg_reg   <= tcw_pkg::RST_FG;
            cfg_bg_reg   <= tcw_pkg::RST_BG;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tcw_pkg::REG_SCREEN_COLUMNS: cfg_cols_reg <= cfg_data[COL_W-1:0];
                tcw_pkg::REG_SCREEN_ROWS:    cfg_rows_reg <= cfg_data[ROW_W-1:0];
                tcw_pkg::REG_DEFAULT_FG:     cfg_fg_reg   <= cfg_data[CLR_W-1:0];
                tcw_pkg::REG_DEFAULT_BG:     cfg_bg_reg   <= cfg_data[CLR_W-1:0];
                default:                     cfg_cols_reg <= cfg_cols_reg;
            endcase
        end
    end

    assign pos_full = IDX_W'(cur_row_reg) * IDX_W'(cols) + IDX_W'(cur_col_reg);

    // ------------------------------------------------------------------------
    // Sequencer: clear pass, accept, read wait, scroll walk, result hand-off
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            src_reg         <= '0;
            fill_reg        <= '0;
            mv_dst_reg      <= '0;
            mv_pend_reg     <= 1'b0;
            scroll_left_reg <= '0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            res_char_reg    <= '0;
            res_attr_reg    <= '0;
            res_scroll_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
        end
        else
        begin
            // Every move read is drained by a write in the following cycle
            mv_pend_reg <= (state_reg == S_MOVE);

            // Raise valid on hand-off, drop it once the item is taken
            if (state_reg == S_DONE && load_ok)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + ADDR_W'(1);
                    if (clr_reg == ADDR_W'(CELL_COUNT - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur_col_reg     <= nxt_col;
                        cur_row_reg     <= nxt_row;
                        res_char_reg    <= '0;
                        res_attr_reg    <= '0;
                        res_scroll_reg  <= (nxt_scroll_cnt != '0);
                        scroll_left_reg <= nxt_scroll_cnt;
                        if (cmd.op == tcw_pkg::OP_READ_CELL)
                            state_reg <= S_RD;
                        else if (nxt_scroll_cnt != '0)
                        begin
                            // A one-row screen has nothing to move
                            src_reg   <= IDX_W'(cols);
                            fill_reg  <= last_base;
                            state_reg <= (rows > ROW_W'(1)) ? S_MOVE : S_FILL;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_RD:
                begin
                    res_char_reg <= rd_data_reg[CHAR_W-1:0];
                    res_attr_reg <= rd_data_reg[CELL_W-1:CHAR_W];
                    state_reg    <= S_DONE;
                end
                S_MOVE:
                begin
                    mv_dst_reg  <= src_reg - IDX_W'(cols);
                    src_reg     <= src_reg + IDX_W'(1);
                    if (src_reg == area - IDX_W'(1))
                    begin
                        fill_reg  <= last_base;
                        state_reg <= S_FILL;
                    end
                end
                S_FILL:
                begin
                    // Hold the fill while the last move drains
                    if (!mv_pend_reg)
                    begin
                        if (fill_reg == area - IDX_W'(1))
                        begin
                            scroll_left_reg <= scroll_left_reg - TROW_W'(1);
                            if (scroll_left_reg == TROW_W'(1))
                                state_reg <= S_DONE;
                            else
                            begin
                                src_reg   <= IDX_W'(cols);
                                fill_reg  <= last_base;
                                state_reg <= (rows > ROW_W'(1)) ? S_MOVE : S_FILL;
                            end
                        end
                        else
                            fill_reg <= fill_reg + IDX_W'(1);
                    end
                end
                S_DONE:
                begin
                    if (load_ok)
                    begin
                        rsp_reg.cursor_position <= pos_full[tcw_pkg::POS_W-1:0];
                        rsp_reg.cursor_column   <= cur_col_reg;
                        rsp_reg.cursor_row      <= cur_row_reg;
                        rsp_reg.cell_char       <= res_char_reg;
                        rsp_reg.cell_attr       <= res_attr_reg;
                        rsp_reg.scrolled        <= res_scroll_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    assign in_walk    = (state_reg == S_MOVE) || (state_reg == S_FILL);
    assign hold_phase = (state_reg == S_DONE) || (state_reg == S_RD);

    // A pending moved cell is always drained inside the scroll walk
    `TCW_ASSERT_NOW(a_move_drained, mv_pend_reg, in_walk, "move write left pending")
    // No store write while a result is waiting for hand-off or a read completes
    `TCW_ASSERT_NOW(a_no_write_done, hold_phase, !wr_en, "store written outside an update")
    // An item that needs a scroll enters the scroll walk next
    `TCW_ASSERT_NEXT(a_scroll_start, accept && nxt_scroll_cnt != '0, in_walk, "scroll not started")
    // A new result only appears from the hand-off state
    `TCW_ASSERT_NOW(a_rsp_source, $rose(rsp_valid_reg), $past(state_reg == S_DONE), "stray result")

endmodule

FILE: sim/tcw_console_checker.sv
// ----------------------------------------------------------------------------
// Text console writer checker
// Watches the command, report and register channels of the console block,
// keeps its own copy of the screen, cursor and settings, works out the cursor
// report for every accepted command and compares it with what comes out.
// ----------------------------------------------------------------------------
module tcw_console_checker #(
    parameter int MAX_COLUMNS = 80,
    parameter int MAX_ROWS    = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  logic                           cmd_ready,
    input  tcw_pkg::cmd_t                  cmd,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  tcw_pkg::rsp_t                  rsp,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             pending,
    output int                             reports_seen,
    output int                             scrolls_seen,
    output int                             cells_read
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;

    logic [tcw_pkg::CELL_W-1:0] screen [0:CELLS-1];
    int unsigned                cur_col;
    int unsigned                cur_row;
    logic [tcw_pkg::COL_W-1:0]  cols_reg;
    logic [tcw_pkg::ROW_W-1:0]  rows_reg;
    logic [tcw_pkg::CLR_W-1:0]  fill_fg;
    logic [tcw_pkg::CLR_W-1:0]  fill_bg;
    tcw_pkg::rsp_t              reports_due [$];
    int                         bad;
    int                         seen;
    int                         scrolls;
    int                         reads;

    function automatic int unsigned cols_in_use();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLUMNS) return MAX_COLUMNS;
        return cols_reg;
    endfunction

    function automatic int unsigned rows_in_use();
        if (rows_reg == 0) return 1;
        if (rows_reg > MAX_ROWS) return MAX_ROWS;
        return rows_reg;
    endfunction

    function automatic int unsigned cell_at(int unsigned col, int unsigned row,
                                            int unsigned nc);
        int unsigned i;
        i = row * nc + col;
        return (i < CELLS) ? i : CELLS - 1;
    endfunction

    // Move every row up by one and blank the bottom row in the fill colours
    function automatic void scroll_screen(int unsigned nc, int unsigned nr);
        int unsigned i;
        for (i = 0; i < nc * (nr - 1); i++)
            screen[i] = screen[i + nc];
        for (i = 0; i < nc; i++)
            screen[cell_at(i, nr - 1, nc)] = {fill_bg, fill_fg, tcw_pkg::BLANK_CHAR};
    endfunction

    function automatic tcw_pkg::rsp_t console_step(tcw_pkg::cmd_t c);
        int unsigned                nc;
        int unsigned                nr;
        int unsigned                col;
        int unsigned                row;
        int unsigned                rc;
        int unsigned                rr;
        logic [tcw_pkg::CELL_W-1:0] cell_word;
        tcw_pkg::rsp_t              r;
        nc = cols_in_use();
        nr = rows_in_use();
        col = (cur_col >= nc) ? nc - 1 : cur_col;
        row = (cur_row >= nr) ? nr - 1 : cur_row;
        r = '0;
        case (c.op)
            tcw_pkg::OP_PUT_CHAR:
            begin
                screen[cell_at(col, row, nc)] = {c.bg_color, c.fg_color, c.char_code};
                col++;
                if (col >= nc)
                begin
                    col = 0;
                    row++;
                end
                if (row >= nr)
                begin
                    scroll_screen(nc, nr);
                    r.scrolled = 1'b1;
                    col = 0;
                    row = nr - 1;
                end
            end
            tcw_pkg::OP_SET_POSITION:
            begin
                col = (c.column >= nc) ? nc - 1 : c.column;
                row = c.row;
                while (row >= nr)
                begin
                    scroll_screen(nc, nr);
                    r.scrolled = 1'b1;
                    row--;
                end
            end
            tcw_pkg::OP_READ_CELL:
            begin
                rc = (c.column >= nc) ? nc - 1 : c.column;
                rr = (c.row >= nr) ? nr - 1 : c.row;
                cell_word = screen[cell_at(rc, rr, nc)];
                r.cell_char = cell_word[tcw_pkg::CHAR_W-1:0];
                r.cell_attr = cell_word[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            end
            default: ;
        endcase
        cur_col = col;
        cur_row = row;
        r.cursor_position = tcw_pkg::POS_W'(row * nc + col);
        r.cursor_column   = tcw_pkg::COL_W'(col);
        r.cursor_row      = tcw_pkg::ROW_W'(row);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tcw_pkg::rsp_t due;
        int            k;
        if (!rst_n)
        begin
            for (k = 0; k < CELLS; k++)
                screen[k] = tcw_pkg::RESET_CELL;
            cur_col  = 0;
            cur_row  = 0;
            cols_reg = tcw_pkg::RST_COLUMNS;
            rows_reg = tcw_pkg::RST_ROWS;
            fill_fg  = tcw_pkg::RST_FG;
            fill_bg  = tcw_pkg::RST_BG;
            reports_due.delete();
            bad     = 0;
            seen    = 0;
            scrolls = 0;
            reads   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tcw_pkg::REG_SCREEN_COLUMNS: cols_reg = cfg_data[tcw_pkg::COL_W-1:0];
                    tcw_pkg::REG_SCREEN_ROWS:    rows_reg = cfg_data[tcw_pkg::ROW_W-1:0];
                    tcw_pkg::REG_DEFAULT_FG:     fill_fg  = cfg_data[tcw_pkg::CLR_W-1:0];
                    tcw_pkg::REG_DEFAULT_BG:     fill_bg  = cfg_data[tcw_pkg::CLR_W-1:0];
                    default: ;
                endcase
            end
            if (cmd_valid && cmd_ready)
            begin
                reports_due.push_back(console_step(cmd));
                if (cmd.op == tcw_pkg::OP_READ_CELL)
                    reads++;
            end
            if (rsp_valid && rsp_ready)
            begin
                seen++;
                if (rsp.scrolled)
                    scrolls++;
                if (reports_due.size() == 0)
                begin
                    bad++;
                    if (bad <= 10)
                        $display("%0t: report with none due: pos %0d col %0d row %0d",
                                 $time, rsp.cursor_position, rsp.cursor_column,
                                 rsp.cursor_row);
                end
                else
                begin
                    due = reports_due.pop_front();
                    if (rsp !== due)
                    begin
                        bad++;
                        if (bad <= 10)
                        begin
                            $display("%0t: report mismatch", $time);
                            $display("  expected pos %0d col %0d row %0d chr %h attr %h scr %b",
                                     due.cursor_position, due.cursor_column,
                                     due.cursor_row, due.cell_char, due.cell_attr,
                                     due.scrolled);
                            $display("  actual   pos %0d col %0d row %0d chr %h attr %h scr %b",
                                     rsp.cursor_position, rsp.cursor_column,
                                     rsp.cursor_row, rsp.cell_char, rsp.cell_attr,
                                     rsp.scrolled);
                        end
                    end
                end
            end
        end
        mismatches   <= bad;
        pending      <= reports_due.size();
        reports_seen <= seen;
        scrolls_seen <= scrolls;
        cells_read   <= reads;
    end

endmodule

FILE: sim/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives directed and random console commands through several screen
// geometries and fill colours, with bursty input and a stalling report sink,
// and leaves all checking to the console checker beside the block.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int MAX_COLUMNS = 80;
    localparam int MAX_ROWS    = 25;
    // Generous ceiling: the clearing pass, one deep set_position scroll at full
    // size and a few hundred stalled items fit many times over.
    localparam int RUN_LIMIT   = 4_000_000;
    localparam int LONG_HOLD   = 400;

    // The unused op code: the block must leave everything alone
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Report sink behaviours
    localparam int SINK_OPEN    = 0;
    localparam int SINK_RANDOM  = 1;
    localparam int SINK_PATTERN = 2;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cmd_valid;
    logic                  cmd_ready;
    cmd_t                  cmd;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int reports_seen;
    int scrolls_seen;
    int cells_read;

    int cycle_count = 0;
    int items_sent  = 0;
    int settings    = 0;
    int burst_left  = 0;
    int geo_cols    = MAX_COLUMNS;
    int geo_rows    = MAX_ROWS;
    int sink_mode   = SINK_OPEN;
    bit calm_source = 1'b0;
    bit hold_req    = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    text_console_writer #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    tcw_console_checker #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending),
        .reports_seen(reports_seen),
        .scrolls_seen(scrolls_seen),
        .cells_read  (cells_read)
    );

    // Watchdog: stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAIL text_console_writer");
            $finish;
        end
    end

    // Report sink. A long hold-off request keeps ready low while the source
    // keeps offering, so the block backs up and has to stall its command input.
    // Otherwise follow the current sink mode.
    initial begin
        int pat;
        pat = 0;
        rsp_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            pat++;
            case (sink_mode)
                SINK_RANDOM:  rsp_ready <= ($urandom_range(0, 99) < 65);
                SINK_PATTERN: rsp_ready <= ((pat % 7) < 4);
                default:      rsp_ready <= 1'b1;
            endcase
        end
    end

    function automatic cmd_t mk(logic [1:0] op, int ch, int fg, int bg, int col, int row);
        cmd_t c;
        c.op        = op;
        c.char_code = CHAR_W'(ch);
        c.fg_color  = CLR_W'(fg);
        c.bg_color  = CLR_W'(bg);
        c.column    = COL_W'(col);
        c.row       = TROW_W'(row);
        return c;
    endfunction

    // Random command shaped to the current geometry. Keep most positions on
    // screen, push some just past the bottom to force scrolls, and only allow
    // deep scrolls where the screen is small enough to walk quickly.
    function automatic cmd_t random_item(int nc, int nr);
        cmd_t c;
        int   pick;
        int   sub;
        c = mk(OP_PUT_CHAR, $urandom_range(0, 255), $urandom_range(0, 15),
               $urandom_range(0, 15), $urandom_range(0, 127), $urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        if (pick < 50) begin
            c.op = OP_PUT_CHAR;
        end else if (pick < 70) begin
            c.op = OP_SET_POSITION;
            if ($urandom_range(0, 99) < 80)
                c.column = COL_W'($urandom_range(0, nc - 1));
            if (sub < 80)
                c.row = TROW_W'($urandom_range(0, nr - 1));
            else if (sub < 95)
                c.row = TROW_W'((nr + $urandom_range(0, 2) > 63) ? 63
                                                                 : nr + $urandom_range(0, 2));
            else if (nc * nr > 200)
                c.row = TROW_W'($urandom_range(0, nr - 1));
        end else if (pick < 95) begin
            c.op = OP_READ_CELL;
            if ($urandom_range(0, 99) < 80)
                c.column = COL_W'($urandom_range(0, nc - 1));
            if (sub < 75)
                c.row = TROW_W'($urandom_range(0, nr - 1));
        end else begin
            c.op = OP_UNUSED;
        end
        return c;
    endfunction

    // Offer one item and hold it until taken. Open a new burst after a random
    // gap unless the source is running flat out; lower valid only when a real
    // gap follows, so back-to-back items keep valid high.
    task automatic send_item(input cmd_t c);
        int gap;
        if (burst_left == 0) begin
            if (calm_source)
                gap = 0;
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(0, 3);
            if (gap > 0) begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and wait for every report to drain
    task automatic drain_reports();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers back to back once every report has drained
    task automatic configure(input int cols, input int rows, input int fg, input int bg);
        int k;
        drain_reports();
        for (k = 0; k < 4; k++) begin
            case (k)
                0: begin
                    cfg_index <= REG_SCREEN_COLUMNS;
                    cfg_data  <= CFG_DATA_W'(cols);
                end
                1: begin
                    cfg_index <= REG_SCREEN_ROWS;
                    cfg_data  <= CFG_DATA_W'(rows);
                end
                2: begin
                    cfg_index <= REG_DEFAULT_FG;
                    cfg_data  <= CFG_DATA_W'(fg);
                end
                default: begin
                    cfg_index <= REG_DEFAULT_BG;
                    cfg_data  <= CFG_DATA_W'(bg);
                end
            endcase
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        // Track the geometry the block will actually use
        geo_cols = (cols == 0) ? 1 : ((cols > MAX_COLUMNS) ? MAX_COLUMNS : cols);
        geo_rows = (rows == 0) ? 1 : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
        settings++;
    endtask

    task automatic run_phase(input int cols, input int rows, input int fg, input int bg,
                             input int count, input bit calm, input int sink,
                             input bit squeeze);
        int n;
        configure(cols, rows, fg, bg);
        calm_source = calm;
        sink_mode   = sink;
        burst_left  = 0;
        if (squeeze)
            hold_req = 1'b1;
        for (n = 0; n < count; n++)
            send_item(random_item(geo_cols, geo_rows));
    endtask

    initial begin
        int p;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at full size, while the clearing pass may still run
        configure(MAX_COLUMNS, MAX_ROWS, 7, 0);
        sink_mode = SINK_RANDOM;
        send_item(mk(OP_PUT_CHAR, 8'h41, 15, 15, 0, 0));
        send_item(mk(OP_PUT_CHAR, 0, 0, 0, 0, 0));
        send_item(mk(OP_PUT_CHAR, 255, 15, 0, 127, 63));
        send_item(mk(OP_READ_CELL, 0, 0, 0, 0, 0));
        send_item(mk(OP_READ_CELL, 0, 0, 0, 1, 0));
        send_item(mk(OP_READ_CELL, 255, 15, 15, 2, 0));
        // Read beyond both edges: column and row saturate
        send_item(mk(OP_READ_CELL, 0, 0, 0, 127, 63));
        // Column past the width saturates on set_position
        send_item(mk(OP_SET_POSITION, 0, 0, 0, 127, 0));
        // Write at the end of a line: wrap to the next row
        send_item(mk(OP_PUT_CHAR, 8'h5a, 10, 5, 0, 0));
        send_item(mk(OP_READ_CELL, 0, 0, 0, 79, 0));
        // Write in the bottom-right cell: wrap and scroll
        send_item(mk(OP_SET_POSITION, 0, 0, 0, 79, 24));
        send_item(mk(OP_PUT_CHAR, 8'h7e, 1, 2, 0, 0));
        send_item(mk(OP_READ_CELL, 0, 0, 0, 79, 23));
        send_item(mk(OP_READ_CELL, 0, 0, 0, 0, 24));
        // One row below the bottom: a single scroll
        send_item(mk(OP_SET_POSITION, 0, 0, 0, 5, 25));
        send_item(mk(OP_UNUSED, 255, 15, 15, 127, 63));
        send_item(mk(OP_READ_CELL, 0, 0, 0, 1, 22));
        send_item(mk(OP_SET_POSITION, 0, 0, 0, 0, 0));
        send_item(mk(OP_PUT_CHAR, 8'h3c, 6, 9, 127, 63));
        // Deepest set_position: scroll once per row past the bottom
        send_item(mk(OP_SET_POSITION, 0, 0, 0, 0, 63));
        send_item(mk(OP_READ_CELL, 0, 0, 0, 0, 0));

        // Random phases. The first one shrinks the screen under a cursor left
        // on the bottom row, so the cursor must be pulled back inside.
        run_phase(0, 0, 15, 15, 40, 1'b0, SINK_RANDOM, 1'b0);
        run_phase(127, 31, 0, 0, 60, 1'b1, SINK_OPEN, 1'b0);
        run_phase(10, 4, 3, 12, 70, 1'b0, SINK_PATTERN, 1'b0);
        run_phase(1, 25, 9, 6, 50, 1'b0, SINK_RANDOM, 1'b0);
        run_phase(80, 1, 14, 1, 50, 1'b1, SINK_PATTERN, 1'b0);
        // Hold the sink off for a long stretch while the source keeps pushing
        run_phase(7, 3, 5, 10, 80, 1'b1, SINK_OPEN, 1'b1);
        for (p = 0; p < 3; p++)
            run_phase($urandom_range(1, 20), $urandom_range(1, 8), $urandom_range(0, 15),
                      $urandom_range(0, 15), 50, 1'(($urandom_range(0, 1))),
                      $urandom_range(0, 2), 1'b0);

        drain_reports();
        repeat (16) @(posedge clk);

        $display("Covered %0d commands over %0d console settings, %0d reports checked",
                 items_sent, settings, reports_seen);
        $display("of which %0d scrolled and %0d read cells back, in %0d cycles",
                 scrolls_seen, cells_read, cycle_count);
        if (mismatches == 0 && pending == 0)
            $display("PASS text_console_writer");
        else
            $display("FAIL text_console_writer");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/text_console_writer.sv
sim/tcw_console_checker.sv
sim/tb_text_console_writer.sv
